// File: hw/rtl/bm1d_pkg.sv
// ----------------------------------------------------------------------------
// bm1d_pkg
// Shared types, constants, command codes and saturating fixed-point helpers
// for the one-dimensional Brent minimizer.
// ----------------------------------------------------------------------------
package bm1d_pkg;

  localparam int unsigned FRACTION_BITS = 48;
  localparam int unsigned CNT_W         = 17;
  localparam int unsigned MAXIT_W       = 16;
  localparam int unsigned TOL_W         = 63;
  localparam int unsigned REL_SHIFT     = 26;
  localparam int unsigned PADDR_W       = 6;

  localparam logic [63:0] GOLD_Q62 = 64'd1761507313396588283;

  typedef logic signed [63:0] word_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam word_t WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam word_t WORD_MIN = 64'sh8000_0000_0000_0000;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LOWER    = 3'd0;
  localparam logic [2:0] REG_UPPER    = 3'd1;
  localparam logic [2:0] REG_MAX_ITER = 3'd2;
  localparam logic [2:0] REG_MAXIMIZE = 3'd3;
  localparam logic [2:0] REG_EVAL_UP  = 3'd4;
  localparam logic [2:0] REG_EVAL_LO  = 3'd5;
  localparam logic [2:0] REG_TOL      = 3'd6;

  typedef struct packed {
    word_t              lower;
    word_t              upper;
    logic [MAXIT_W-1:0] max_iter;
    logic               maximize;
    logic               eval_upper;
    logic               eval_lower;
    logic [TOL_W-1:0]   tol;
  } cfg_t;

  typedef struct packed {
    logic conv;
    logic iter_over;
    logic esel;
    logic para;
    logic mul_done;
    logic div_done;
  } stat_t;

  typedef enum logic [5:0] {
    CMD_NONE, CMD_INIT, CMD_MUL_GOLD_TA, CMD_REQ_START, CMD_LOADF, CMD_FIRST,
    CMD_UPD, CMD_FCMP, CMD_A0, CMD_A1, CMD_A2, CMD_ITER,
    CMD_MUL_R, CMD_WR_R, CMD_MUL_Q, CMD_WR_Q, CMD_MUL_T1, CMD_WR_P,
    CMD_MUL_T2, CMD_WR_P2, CMD_PQ, CMD_MUL_QR, CMD_WR_QR, CMD_MUL_QL,
    CMD_WR_QL, CMD_MUL_QU, CMD_WR_QU, CMD_DIV, CMD_WR_D, CMD_CHK,
    CMD_GOLD_E, CMD_MUL_GE, CMD_WR_GD, CMD_REQ_S, CMD_REQ_U, CMD_REQ_L,
    CMD_EMIT_REQ, CMD_EMIT_FIN
  } cmd_e;

  function automatic word_t sadd(word_t a, word_t b);
    word_t r;
    r = a + b;
    if (!a[63] && !b[63] && r[63]) return WORD_MAX;
    if (a[63] && b[63] && !r[63]) return WORD_MIN;
    return r;
  endfunction

  function automatic word_t ssub(word_t a, word_t b);
    word_t r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) return a[63] ? WORD_MIN : WORD_MAX;
    return r;
  endfunction

  function automatic word_t sneg(word_t a);
    return (a == WORD_MIN) ? WORD_MAX : -a;
  endfunction

  function automatic word_t sabs(word_t a);
    return a[63] ? sneg(a) : a;
  endfunction

  function automatic logic [63:0] mag(word_t a);
    return a[63] ? (64'd0 - 64'(a)) : 64'(a);
  endfunction

  // floor((l + u) / 2) without overflow
  function automatic word_t midpoint(word_t l, word_t u);
    return (l >>> 1) + (u >>> 1) + word_t'({63'd0, l[0] & u[0]});
  endfunction

  // (3 - sqrt 5) / 2 rounded to nearest at fb fraction bits
  function automatic word_t gold_fn(int unsigned fb);
    return word_t'((GOLD_Q62 + (64'd1 << (61 - fb))) >> (62 - fb));
  endfunction

endpackage

// File: hw/rtl/bm1d_mul.sv
// ----------------------------------------------------------------------------
// bm1d_mul
// Fixed-point multiplier: four 32x32 partial products accumulated in turn,
// then sign, floor shift by the fraction width and saturation.
// ----------------------------------------------------------------------------
module bm1d_mul #(
  parameter int unsigned FB = bm1d_pkg::FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bm1d_pkg::word_t   a_i,
  input  bm1d_pkg::word_t   b_i,
  output logic              done_o,
  output bm1d_pkg::word_t   res_o
);

  logic [63:0]      ua_q, ub_q;
  logic             neg_q;
  logic [127:0]     acc_q;
  logic [1:0]       step_q;
  logic             busy_q, fin_q, done_q;
  bm1d_pkg::word_t  res_q;

  logic [31:0]      a_half, b_half;
  logic [63:0]      pp;
  logic [1:0]       sum;
  logic [127:0]     pp_sh, prod;
  logic [64-FB:0]   hi;
  logic             sat_ok;

  always_comb begin
    a_half = step_q[1] ? ua_q[63:32] : ua_q[31:0];
    b_half = step_q[0] ? ub_q[63:32] : ub_q[31:0];
    pp     = a_half * b_half;
    sum    = {1'b0, step_q[1]} + {1'b0, step_q[0]};
    pp_sh  = {64'd0, pp} << {sum, 5'b0};
    prod   = neg_q ? (128'd0 - acc_q) : acc_q;
    hi     = prod[127:63+FB];
    sat_ok = (&hi) | ~(|hi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
      end else if (busy_q) begin
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q   <= bm1d_pkg::mag(a_i);
      ub_q   <= bm1d_pkg::mag(b_i);
      neg_q  <= a_i[63] ^ b_i[63];
      acc_q  <= '0;
      step_q <= 2'd0;
    end else if (busy_q) begin
      acc_q  <= acc_q + pp_sh;
      step_q <= step_q + 2'd1;
    end else if (fin_q) begin
      if (sat_ok) res_q <= bm1d_pkg::word_t'(prod[63+FB:FB]);
      else res_q <= prod[127] ? bm1d_pkg::WORD_MIN : bm1d_pkg::WORD_MAX;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hw/rtl/bm1d_div.sv
// ----------------------------------------------------------------------------
// bm1d_div
// Fixed-point divider: restoring division one quotient bit per cycle,
// truncating toward zero, with saturation and zero for a zero divisor.
// ----------------------------------------------------------------------------
module bm1d_div #(
  parameter int unsigned FB = bm1d_pkg::FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bm1d_pkg::word_t   p_i,
  input  bm1d_pkg::word_t   q_i,
  output logic              done_o,
  output bm1d_pkg::word_t   res_o
);

  localparam int unsigned NW = 64 + FB;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]    num_q, quo_q;
  logic [63:0]      den_q, rem_q;
  logic [CW-1:0]    cnt_q;
  logic             neg_q, zero_q, busy_q, fin_q, done_q;
  bm1d_pkg::word_t  res_q;

  logic [64:0]      rem_sh, rem_sub;
  logic             take;
  logic             hi_nz;
  logic [63:0]      lo;

  always_comb begin
    rem_sh  = {rem_q, num_q[NW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    take    = rem_sh >= {1'b0, den_q};
    hi_nz   = |quo_q[NW-1:64];
    lo      = quo_q[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
      end else if (busy_q) begin
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= {bm1d_pkg::mag(p_i), FB'(0)};
      den_q  <= bm1d_pkg::mag(q_i);
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= CW'(NW);
      neg_q  <= p_i[63] ^ q_i[63];
      zero_q <= (q_i == '0);
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      quo_q <= {quo_q[NW-2:0], take};
      rem_q <= take ? rem_sub[63:0] : rem_sh[63:0];
      cnt_q <= cnt_q - CW'(1);
    end else if (fin_q) begin
      if (zero_q) res_q <= '0;
      else if (neg_q) begin
        if (hi_nz || (lo > 64'h8000_0000_0000_0000)) res_q <= bm1d_pkg::WORD_MIN;
        else res_q <= bm1d_pkg::word_t'(64'd0 - lo);
      end else begin
        if (hi_nz || lo[63]) res_q <= bm1d_pkg::WORD_MAX;
        else res_q <= bm1d_pkg::word_t'(lo);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hw/rtl/bm1d_dp.sv
// ----------------------------------------------------------------------------
// bm1d_dp
// Datapath: search state, scratch registers, shared multiplier and divider,
// result register. Each controller command performs one short step.
// ----------------------------------------------------------------------------
module bm1d_dp #(
  parameter int unsigned FB = bm1d_pkg::FRACTION_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bm1d_pkg::cmd_e     cmd_i,
  input  bm1d_pkg::cfg_t     cfg_i,
  input  bm1d_pkg::word_t    obj_i,
  output bm1d_pkg::stat_t    stat_o,
  output logic               kind_o,
  output bm1d_pkg::word_t    point_o,
  output bm1d_pkg::word_t    best_obj_o,
  output bm1d_pkg::cnt_t     best_idx_o,
  output bm1d_pkg::cnt_t     iter_o
);

  localparam bm1d_pkg::word_t GOLD = bm1d_pkg::gold_fn(FB);

  bm1d_pkg::word_t x_q, w_q, v_q, fx_q, fw_q, fv_q, e_q, d_q;
  bm1d_pkg::word_t lo_q, hi_q, pend_q, f_q;
  bm1d_pkg::word_t ta_q, tb_q, p_q, q_q, r_q, m_q, tol_q, tol2_q;
  bm1d_pkg::cnt_t  iter_q, evc_q, bidx_q;
  logic            c1_q, c2_q, c3_q;

  logic            kind_q;
  bm1d_pkg::word_t point_q, bobj_q;
  bm1d_pkg::cnt_t  oidx_q, oiter_q;

  bm1d_pkg::word_t ma, mb, mul_res, div_res;
  logic            mul_start, div_start, mul_done, div_done;
  logic [63:0]     magx;
  bm1d_pkg::word_t tolw, znext, q2, req_z;

  always_comb begin
    ma = '0;
    mb = '0;
    mul_start = 1'b1;
    case (cmd_i)
      bm1d_pkg::CMD_MUL_GOLD_TA: begin ma = GOLD; mb = ta_q; end
      bm1d_pkg::CMD_MUL_R: begin
        ma = bm1d_pkg::ssub(x_q, w_q); mb = bm1d_pkg::ssub(fx_q, fv_q);
      end
      bm1d_pkg::CMD_MUL_Q: begin
        ma = bm1d_pkg::ssub(x_q, v_q); mb = bm1d_pkg::ssub(fx_q, fw_q);
      end
      bm1d_pkg::CMD_MUL_T1: begin ma = bm1d_pkg::ssub(x_q, v_q); mb = q_q; end
      bm1d_pkg::CMD_MUL_T2: begin ma = bm1d_pkg::ssub(x_q, w_q); mb = r_q; end
      bm1d_pkg::CMD_MUL_QR: begin ma = q_q; mb = r_q; end
      bm1d_pkg::CMD_MUL_QL: begin ma = q_q; mb = bm1d_pkg::ssub(lo_q, x_q); end
      bm1d_pkg::CMD_MUL_QU: begin ma = q_q; mb = bm1d_pkg::ssub(hi_q, x_q); end
      bm1d_pkg::CMD_MUL_GE: begin ma = GOLD; mb = e_q; end
      default: mul_start = 1'b0;
    endcase
  end

  assign div_start = (cmd_i == bm1d_pkg::CMD_DIV);

  always_comb begin
    magx = bm1d_pkg::mag(x_q);
    tolw = bm1d_pkg::word_t'({1'b0, cfg_i.tol});
    q2   = bm1d_pkg::sadd(ta_q, ta_q);
    if (bm1d_pkg::sabs(d_q) >= tol_q) znext = bm1d_pkg::sadd(x_q, d_q);
    else if (d_q > 0) znext = bm1d_pkg::sadd(x_q, tol_q);
    else znext = bm1d_pkg::ssub(x_q, tol_q);
    case (cmd_i)
      bm1d_pkg::CMD_REQ_START: req_z = bm1d_pkg::sadd(cfg_i.lower, mul_res);
      bm1d_pkg::CMD_REQ_U:     req_z = cfg_i.upper;
      bm1d_pkg::CMD_REQ_L:     req_z = cfg_i.lower;
      default:                 req_z = znext;
    endcase
  end

  bm1d_mul #(.FB(FB)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (ma),
    .b_i     (mb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  bm1d_div #(.FB(FB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (p_q),
    .q_i     (q_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // architectural search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; w_q <= '0; v_q <= '0;
      fx_q <= '0; fw_q <= '0; fv_q <= '0;
      e_q <= '0; d_q <= '0;
      lo_q <= '0; hi_q <= '0; pend_q <= '0;
      iter_q <= '0; evc_q <= '0; bidx_q <= '0;
    end else begin
      case (cmd_i)
        bm1d_pkg::CMD_INIT: begin
          lo_q <= cfg_i.lower; hi_q <= cfg_i.upper;
          x_q <= '0; w_q <= '0; v_q <= '0;
          fx_q <= '0; fw_q <= '0; fv_q <= '0;
          e_q <= '0; d_q <= '0;
          iter_q <= '0; evc_q <= '0; bidx_q <= '0;
        end
        bm1d_pkg::CMD_REQ_START, bm1d_pkg::CMD_REQ_S, bm1d_pkg::CMD_REQ_U,
        bm1d_pkg::CMD_REQ_L: begin
          pend_q <= req_z;
          evc_q  <= evc_q + 1'b1;
        end
        bm1d_pkg::CMD_FIRST: begin
          x_q <= pend_q; w_q <= pend_q; v_q <= pend_q;
          fx_q <= f_q; fw_q <= f_q; fv_q <= f_q;
          e_q <= '0; d_q <= '0;
          bidx_q <= evc_q;
        end
        bm1d_pkg::CMD_UPD: begin
          if (f_q <= fx_q) begin
            if (pend_q < x_q) hi_q <= x_q;
            else lo_q <= x_q;
            v_q <= w_q; fv_q <= fw_q;
            w_q <= x_q; fw_q <= fx_q;
            x_q <= pend_q; fx_q <= f_q;
            bidx_q <= evc_q;
          end else begin
            if (pend_q < x_q) lo_q <= pend_q;
            else hi_q <= pend_q;
            if ((f_q <= fw_q) || (w_q == x_q)) begin
              v_q <= w_q; fv_q <= fw_q;
              w_q <= pend_q; fw_q <= f_q;
            end else if ((f_q <= fv_q) || (v_q == x_q) || (v_q == w_q)) begin
              v_q <= pend_q; fv_q <= f_q;
            end
          end
        end
        bm1d_pkg::CMD_FCMP: begin
          if (f_q < fx_q) begin
            fx_q <= f_q; x_q <= pend_q; bidx_q <= evc_q;
          end
        end
        bm1d_pkg::CMD_ITER: iter_q <= iter_q + 1'b1;
        bm1d_pkg::CMD_PQ: begin
          e_q <= d_q;
        end
        bm1d_pkg::CMD_WR_D: d_q <= div_res;
        bm1d_pkg::CMD_CHK: begin
          if ((bm1d_pkg::ssub(tb_q, lo_q) < tol2_q) || (bm1d_pkg::ssub(hi_q, tb_q) < tol2_q))
            d_q <= (x_q < m_q) ? tol_q : bm1d_pkg::sneg(tol_q);
        end
        bm1d_pkg::CMD_GOLD_E: begin
          e_q <= (x_q < m_q) ? bm1d_pkg::ssub(hi_q, x_q) : bm1d_pkg::ssub(lo_q, x_q);
        end
        bm1d_pkg::CMD_WR_GD: d_q <= mul_res;
        default: ;
      endcase
    end
  end

  // scratch registers of one step
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      bm1d_pkg::CMD_INIT: ta_q <= bm1d_pkg::ssub(cfg_i.upper, cfg_i.lower);
      bm1d_pkg::CMD_LOADF: f_q <= cfg_i.maximize ? bm1d_pkg::sneg(obj_i) : obj_i;
      bm1d_pkg::CMD_A0: begin
        m_q   <= bm1d_pkg::midpoint(lo_q, hi_q);
        tol_q <= bm1d_pkg::sadd(bm1d_pkg::word_t'(magx >> bm1d_pkg::REL_SHIFT), tolw);
      end
      bm1d_pkg::CMD_A1: begin
        tol2_q <= bm1d_pkg::sadd(tol_q, tol_q);
        ta_q   <= bm1d_pkg::sabs(bm1d_pkg::ssub(x_q, m_q));
        tb_q   <= bm1d_pkg::ssub(hi_q, lo_q) >>> 1;
      end
      bm1d_pkg::CMD_A2: tb_q <= bm1d_pkg::ssub(tol2_q, tb_q);
      bm1d_pkg::CMD_WR_R: r_q <= mul_res;
      bm1d_pkg::CMD_WR_Q: q_q <= mul_res;
      bm1d_pkg::CMD_WR_P: p_q <= mul_res;
      bm1d_pkg::CMD_WR_P2: begin
        p_q  <= bm1d_pkg::ssub(p_q, mul_res);
        ta_q <= bm1d_pkg::ssub(q_q, r_q);
      end
      bm1d_pkg::CMD_PQ: begin
        if (q2 > 0) begin
          p_q <= bm1d_pkg::sneg(p_q);
          q_q <= q2;
        end else begin
          q_q <= bm1d_pkg::sneg(q2);
        end
        r_q <= e_q;
      end
      bm1d_pkg::CMD_WR_QR: c1_q <= bm1d_pkg::sabs(p_q) < bm1d_pkg::sabs(mul_res >>> 1);
      bm1d_pkg::CMD_WR_QL: c2_q <= p_q < mul_res;
      bm1d_pkg::CMD_WR_QU: c3_q <= p_q < mul_res;
      bm1d_pkg::CMD_WR_D:  tb_q <= bm1d_pkg::sadd(x_q, div_res);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i == bm1d_pkg::CMD_EMIT_REQ || cmd_i == bm1d_pkg::CMD_EMIT_FIN) begin
      kind_q  <= (cmd_i == bm1d_pkg::CMD_EMIT_FIN);
      point_q <= (cmd_i == bm1d_pkg::CMD_EMIT_FIN) ? x_q : pend_q;
      bobj_q  <= cfg_i.maximize ? bm1d_pkg::sneg(fx_q) : fx_q;
      oidx_q  <= bidx_q;
      oiter_q <= iter_q;
    end
  end

  always_comb begin
    stat_o.conv      = ta_q <= tb_q;
    stat_o.iter_over = iter_q > {1'b0, cfg_i.max_iter};
    stat_o.esel      = bm1d_pkg::sabs(e_q) > tol_q;
    stat_o.para      = c1_q & c2_q & c3_q;
    stat_o.mul_done  = mul_done;
    stat_o.div_done  = div_done;
  end

  assign kind_o     = kind_q;
  assign point_o    = point_q;
  assign best_obj_o = bobj_q;
  assign best_idx_o = oidx_q;
  assign iter_o     = oiter_q;

endmodule

// File: hw/rtl/bm1d_ctrl.sv
// ----------------------------------------------------------------------------
// bm1d_ctrl
// Controller: sequences the datapath steps of one transaction, keeps the
// search phase and drives the channel handshakes.
// ----------------------------------------------------------------------------
module bm1d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              action_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bm1d_pkg::cfg_t    cfg_i,
  input  bm1d_pkg::stat_t   stat_i,
  output bm1d_pkg::cmd_e    cmd_o
);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_SEARCH = 5'b00100,
    PH_UPPER  = 5'b01000,
    PH_LOWER  = 5'b10000
  } phase_e;

  typedef enum logic [38:0] {
    S_WAIT = 39'd1 << 0,   S_INIT = 39'd1 << 1,   S_SMUL = 39'd1 << 2,
    S_SREQ = 39'd1 << 3,   S_FIRST = 39'd1 << 4,  S_UPD = 39'd1 << 5,
    S_FCMP = 39'd1 << 6,   S_A0 = 39'd1 << 7,     S_A1 = 39'd1 << 8,
    S_A2 = 39'd1 << 9,     S_A3 = 39'd1 << 10,    S_A4 = 39'd1 << 11,
    S_MR = 39'd1 << 12,    S_WR = 39'd1 << 13,    S_MQ = 39'd1 << 14,
    S_WQ = 39'd1 << 15,    S_MT1 = 39'd1 << 16,   S_WP = 39'd1 << 17,
    S_MT2 = 39'd1 << 18,   S_WP2 = 39'd1 << 19,   S_PQ = 39'd1 << 20,
    S_MQR = 39'd1 << 21,   S_WQR = 39'd1 << 22,   S_MQL = 39'd1 << 23,
    S_WQL = 39'd1 << 24,   S_MQU = 39'd1 << 25,   S_WQU = 39'd1 << 26,
    S_SEL = 39'd1 << 27,   S_DIV = 39'd1 << 28,   S_WD = 39'd1 << 29,
    S_CHK = 39'd1 << 30,   S_GE = 39'd1 << 31,    S_MGE = 39'd1 << 32,
    S_WGD = 39'd1 << 33,   S_REQS = 39'd1 << 34,  S_REQU = 39'd1 << 35,
    S_REQL = 39'd1 << 36,  S_EREQ = 39'd1 << 37,  S_EFIN = 39'd1 << 38
  } state_e;

  state_e         state_q, state_d, end_st, au_st;
  phase_e         phase_q, phase_d;
  logic           out_valid_q, out_valid_d;
  logic           can_emit;
  bm1d_pkg::cmd_e cmd;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd         = bm1d_pkg::CMD_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    can_emit    = !out_valid_q || !out_stall_i;
    // where the search loop and the upper bound check continue
    end_st = cfg_i.eval_upper ? S_REQU : (cfg_i.eval_lower ? S_REQL : S_EFIN);
    au_st  = cfg_i.eval_lower ? S_REQL : S_EFIN;
    unique case (state_q)
      S_WAIT: begin
        if (in_valid_i) begin
          if (!action_i) state_d = S_INIT;
          else if (phase_q != PH_IDLE) begin
            cmd = bm1d_pkg::CMD_LOADF;
            unique case (phase_q)
              PH_FIRST:  state_d = S_FIRST;
              PH_SEARCH: state_d = S_UPD;
              default:   state_d = S_FCMP;
            endcase
          end
        end
      end
      S_INIT: begin
        cmd = bm1d_pkg::CMD_INIT; phase_d = PH_FIRST; state_d = S_SMUL;
      end
      S_SMUL: begin cmd = bm1d_pkg::CMD_MUL_GOLD_TA; state_d = S_SREQ; end
      S_SREQ: if (stat_i.mul_done) begin
        cmd = bm1d_pkg::CMD_REQ_START; state_d = S_EREQ;
      end
      S_FIRST: begin cmd = bm1d_pkg::CMD_FIRST; state_d = S_A0; end
      S_UPD:   begin cmd = bm1d_pkg::CMD_UPD; state_d = S_A0; end
      S_FCMP: begin
        cmd = bm1d_pkg::CMD_FCMP;
        state_d = (phase_q == PH_UPPER) ? au_st : S_EFIN;
      end
      S_A0: begin cmd = bm1d_pkg::CMD_A0; state_d = S_A1; end
      S_A1: begin cmd = bm1d_pkg::CMD_A1; state_d = S_A2; end
      S_A2: begin cmd = bm1d_pkg::CMD_A2; state_d = S_A3; end
      S_A3: begin
        if (stat_i.conv) state_d = end_st;
        else begin cmd = bm1d_pkg::CMD_ITER; state_d = S_A4; end
      end
      S_A4: begin
        if (stat_i.iter_over) state_d = end_st;
        else state_d = stat_i.esel ? S_MR : S_GE;
      end
      S_MR:  begin cmd = bm1d_pkg::CMD_MUL_R; state_d = S_WR; end
      S_WR:  if (stat_i.mul_done) begin cmd = bm1d_pkg::CMD_WR_R; state_d = S_MQ; end
      S_MQ:  begin cmd = bm1d_pkg::CMD_MUL_Q; state_d = S_WQ; end
      S_WQ:  if (stat_i.mul_done) begin cmd = bm1d_pkg::CMD_WR_Q; state_d = S_MT1; end
      S_MT1: begin cmd = bm1d_pkg::CMD_MUL_T1; state_d = S_WP; end
      S_WP:  if (stat_i.mul_done) begin cmd = bm1d_pkg::CMD_WR_P; state_d = S_MT2; end
      S_MT2: begin cmd = bm1d_pkg::CMD_MUL_T2; state_d = S_WP2; end
      S_WP2: if (stat_i.mul_done) begin cmd = bm1d_pkg::CMD_WR_P2; state_d = S_PQ; end
      S_PQ:  begin cmd = bm1d_pkg::CMD_PQ; state_d = S_MQR; end
      S_MQR: begin cmd = bm1d_pkg::CMD_MUL_QR; state_d = S_WQR; end
      S_WQR: if (stat_i.mul_done) begin cmd = bm1d_pkg::CMD_WR_QR; state_d = S_MQL; end
      S_MQL: begin cmd = bm1d_pkg::CMD_MUL_QL; state_d = S_WQL; end
      S_WQL: if (stat_i.mul_done) begin cmd = bm1d_pkg::CMD_WR_QL; state_d = S_MQU; end
      S_MQU: begin cmd = bm1d_pkg::CMD_MUL_QU; state_d = S_WQU; end
      S_WQU: if (stat_i.mul_done) begin cmd = bm1d_pkg::CMD_WR_QU; state_d = S_SEL; end
      S_SEL: state_d = stat_i.para ? S_DIV : S_GE;
      S_DIV: begin cmd = bm1d_pkg::CMD_DIV; state_d = S_WD; end
      S_WD:  if (stat_i.div_done) begin cmd = bm1d_pkg::CMD_WR_D; state_d = S_CHK; end
      S_CHK: begin cmd = bm1d_pkg::CMD_CHK; state_d = S_REQS; end
      S_GE:  begin cmd = bm1d_pkg::CMD_GOLD_E; state_d = S_MGE; end
      S_MGE: begin cmd = bm1d_pkg::CMD_MUL_GE; state_d = S_WGD; end
      S_WGD: if (stat_i.mul_done) begin cmd = bm1d_pkg::CMD_WR_GD; state_d = S_REQS; end
      S_REQS: begin
        cmd = bm1d_pkg::CMD_REQ_S; phase_d = PH_SEARCH; state_d = S_EREQ;
      end
      S_REQU: begin
        cmd = bm1d_pkg::CMD_REQ_U; phase_d = PH_UPPER; state_d = S_EREQ;
      end
      S_REQL: begin
        cmd = bm1d_pkg::CMD_REQ_L; phase_d = PH_LOWER; state_d = S_EREQ;
      end
      S_EREQ: if (can_emit) begin
        cmd = bm1d_pkg::CMD_EMIT_REQ; out_valid_d = 1'b1; state_d = S_WAIT;
      end
      S_EFIN: if (can_emit) begin
        cmd = bm1d_pkg::CMD_EMIT_FIN; out_valid_d = 1'b1;
        phase_d = PH_IDLE; state_d = S_WAIT;
      end
      default: state_d = S_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_WAIT;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_WAIT);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: hw/rtl/brent_minimizer_1d_core.sv
// ----------------------------------------------------------------------------
// brent_minimizer_1d_core
// One-dimensional Brent minimizer in Q16.48 that drives an external
// evaluator: a start transaction returns the first point to evaluate, and
// each objective value sent back returns the next point or the final
// result. Work is done one transaction at a time by a sequencer over a
// shared multiplier and a bit-serial divider. The result register frees
// the input as soon as a result is written, so the next transaction may
// enter while the result still waits to be taken.
// ----------------------------------------------------------------------------
module brent_minimizer_1d_core #(
  parameter int unsigned FRACTION_BITS = bm1d_pkg::FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bm1d_pkg::PADDR_W-1:0]   paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic signed [63:0]             objective_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           kind_o,
  output logic signed [63:0]             point_o,
  output logic signed [63:0]             best_objective_o,
  output logic [16:0]                    best_eval_index_o,
  output logic [16:0]                    iterations_used_o
);

  bm1d_pkg::cfg_t  cfg_q;
  bm1d_pkg::stat_t stat;
  bm1d_pkg::cmd_e  cmd;
  logic            wr_en;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower      <= '0;
      cfg_q.upper      <= 64'sd281474976710656;
      cfg_q.max_iter   <= 16'd1000;
      cfg_q.maximize   <= 1'b0;
      cfg_q.eval_upper <= 1'b0;
      cfg_q.eval_lower <= 1'b0;
      cfg_q.tol        <= 63'd281475;
    end else if (wr_en) begin
      unique case (reg_idx)
        bm1d_pkg::REG_LOWER:    cfg_q.lower      <= pwdata;
        bm1d_pkg::REG_UPPER:    cfg_q.upper      <= pwdata;
        bm1d_pkg::REG_MAX_ITER: cfg_q.max_iter   <= pwdata[15:0];
        bm1d_pkg::REG_MAXIMIZE: cfg_q.maximize   <= pwdata[0];
        bm1d_pkg::REG_EVAL_UP:  cfg_q.eval_upper <= pwdata[0];
        bm1d_pkg::REG_EVAL_LO:  cfg_q.eval_lower <= pwdata[0];
        bm1d_pkg::REG_TOL:      cfg_q.tol        <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bm1d_pkg::REG_LOWER:    prdata = cfg_q.lower;
      bm1d_pkg::REG_UPPER:    prdata = cfg_q.upper;
      bm1d_pkg::REG_MAX_ITER: prdata = {48'd0, cfg_q.max_iter};
      bm1d_pkg::REG_MAXIMIZE: prdata = {63'd0, cfg_q.maximize};
      bm1d_pkg::REG_EVAL_UP:  prdata = {63'd0, cfg_q.eval_upper};
      bm1d_pkg::REG_EVAL_LO:  prdata = {63'd0, cfg_q.eval_lower};
      bm1d_pkg::REG_TOL:      prdata = {1'b0, cfg_q.tol};
      default:                prdata = '0;
    endcase
  end

  bm1d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_i       (cfg_q),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bm1d_dp #(.FB(FRACTION_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .obj_i      (objective_value_i),
    .stat_o     (stat),
    .kind_o     (kind_o),
    .point_o    (point_o),
    .best_obj_o (best_objective_o),
    .best_idx_o (best_eval_index_o),
    .iter_o     (iterations_used_o)
  );

  // a start transaction always leads into a computation
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !action_i |=> in_stall_o)
    else $error("start transaction did not begin a computation");

  // a new result comes only out of a computation
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a computation");

endmodule
